### sv/erc_pkg.sv
// Shared types and constants for the extent run coalescer.
// No dependencies; imported by every module of the block.
`default_nettype none

package erc_pkg;

    // Widest group index over the supported group-count range (up to 1024 groups)
    localparam int GROUP_IDX_W = 10;
    localparam int OWNER_W     = 64;
    localparam int FSB_W       = 64;
    localparam int START_W     = 32;
    localparam int RUNLEN_W    = 32;
    localparam int OFFSET_W    = 54;
    localparam int LEN_W       = 21;
    localparam int FGROUP_W    = 4;
    localparam int OGROUP_W    = 4;
    localparam int SHIFT_W     = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    localparam int QUEUE_DEPTH = 2;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT  = 1'b1;

    localparam logic               ENABLE_RESET = 1'b1;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET  = 5'd16;

    // Classified request passed from front to back
    typedef struct packed {
        logic                   cmd;
        logic [GROUP_IDX_W-1:0] group;
        logic [OWNER_W-1:0]     owner;
        logic [START_W-1:0]     start;
        logic [LEN_W-1:0]       length;
        logic [OFFSET_W-1:0]    offset;
        logic [1:0]             flags;   // bit 0 attr fork, bit 1 unwritten
    } item_t;

    // One pending record of the group table
    typedef struct packed {
        logic                valid;
        logic [OWNER_W-1:0]  owner;
        logic [START_W-1:0]  start;
        logic [RUNLEN_W-1:0] length;
        logic [OFFSET_W-1:0] offset;
        logic [1:0]          flags;
    } rec_t;

endpackage

`default_nettype wire

### sv/erc_front.sv
// Front end: configuration registers, group split and request filtering.
// Depends on erc_pkg; feeds erc_queue.
`default_nettype none

module erc_front
    import erc_pkg::*;
#(
    parameter int GROUP_COUNT = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  command,
    input  wire logic [OWNER_W-1:0]    owner_id,
    input  wire logic                  attr_fork,
    input  wire logic                  unwritten,
    input  wire logic [FSB_W-1:0]      start_fs_block,
    input  wire logic [OFFSET_W-1:0]   logical_offset,
    input  wire logic [LEN_W-1:0]      length,
    input  wire logic [FGROUP_W-1:0]   flush_group,
    input  wire logic                  q_full,
    input  wire logic                  clearing,
    output logic                       q_push,
    output item_t                      q_item
);

    logic               enable_reg;
    logic [SHIFT_W-1:0] shift_reg;

    logic [FSB_W-1:0] grp_full;
    logic [FSB_W-1:0] start_mask;
    logic [FSB_W-1:0] start_full;
    logic             add_ok;
    logic             flush_ok;
    logic             keep;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= ENABLE_RESET;
            shift_reg  <= SHIFT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_SHIFT:  shift_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        grp_full   = start_fs_block >> shift_reg;
        start_mask = (64'd1 << shift_reg) - 64'd1;
        start_full = start_fs_block & start_mask;
        add_ok     = grp_full < 64'(GROUP_COUNT);
        flush_ok   = 32'(flush_group) < 32'(GROUP_COUNT);
        keep       = enable_reg && ((command == CMD_FLUSH) ? flush_ok : add_ok);
    end

    assign in_stall = q_full || clearing;
    assign q_push   = in_valid && !in_stall && keep;

    always_comb
    begin
        q_item.cmd    = command;
        q_item.group  = (command == CMD_FLUSH) ? GROUP_IDX_W'(flush_group)
                                               : grp_full[GROUP_IDX_W-1:0];
        q_item.owner  = owner_id;
        q_item.start  = start_full[START_W-1:0];
        q_item.length = length;
        q_item.offset = logical_offset;
        q_item.flags  = {unwritten, attr_fork};
    end

endmodule

`default_nettype wire

### sv/erc_queue.sv
// Short request queue between front and back, so each side stalls on its own.
// Depends on erc_pkg.
`default_nettype none

module erc_queue
    import erc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  item_t      push_item,
    input  wire logic  pop,
    output logic       full,
    output logic       head_valid,
    output item_t      head_item
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    item_t          q_mem_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;

    assign full       = (count_reg == QCW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

### sv/erc_back.sv
// Back end: per-group record table, merge decision and output register.
// Depends on erc_pkg; drains erc_queue.
`default_nettype none

module erc_back
    import erc_pkg::*;
#(
    parameter int          GROUP_COUNT    = 16,
    parameter logic [31:0] MAX_RUN_LENGTH = 32'hFFFF_FFFF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 head_valid,
    input  item_t                     head_item,
    output logic                      pop,
    output logic                      clearing,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [OGROUP_W-1:0]       out_group,
    output logic [OWNER_W-1:0]        out_owner,
    output logic [START_W-1:0]        out_start_block,
    output logic [RUNLEN_W-1:0]       out_length,
    output logic [OFFSET_W-1:0]       out_offset,
    output logic                      out_attr_fork,
    output logic                      out_unwritten
);

    localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

    rec_t          tbl_mem [GROUP_COUNT];
    rec_t          rd_reg;
    logic          clr_busy_reg;
    logic [GW-1:0] clr_cnt_reg;
    logic          b_valid_reg;
    item_t         b_item_reg;
    logic          fwd_valid_reg;
    logic [GW-1:0] fwd_addr_reg;
    rec_t          fwd_rec_reg;
    logic          out_valid_reg;
    item_t         out_item_reg;
    rec_t          out_rec_reg;

    logic          out_free;
    logic          adv;
    logic          b_fire;
    logic [GW-1:0] b_addr;
    rec_t          entry;
    rec_t          new_rec;
    rec_t          load_rec;
    logic          emit;
    logic          can_merge;
    logic [32:0]   start_sum;
    logic [32:0]   len_sum;
    logic [54:0]   off_sum;
    logic          wr_en;
    logic [GW-1:0] wr_addr;
    rec_t          wr_data;

    assign clearing = clr_busy_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign adv      = !b_valid_reg || out_free;
    assign pop      = head_valid && adv && !clr_busy_reg;
    assign b_fire   = b_valid_reg && adv;
    assign b_addr   = b_item_reg.group[GW-1:0];

    // Take the record just written when the read raced that write
    assign entry = (fwd_valid_reg && (fwd_addr_reg == b_addr)) ? fwd_rec_reg : rd_reg;

    always_comb
    begin
        load_rec.valid  = 1'b1;
        load_rec.owner  = b_item_reg.owner;
        load_rec.start  = b_item_reg.start;
        load_rec.length = RUNLEN_W'(b_item_reg.length);
        load_rec.offset = b_item_reg.offset;
        load_rec.flags  = b_item_reg.flags;

        start_sum = {1'b0, entry.start} + {1'b0, entry.length};
        len_sum   = {1'b0, entry.length} + 33'(b_item_reg.length);
        off_sum   = {1'b0, entry.offset} + 55'(entry.length);

        can_merge = (entry.owner == b_item_reg.owner)
                 && (start_sum == {1'b0, b_item_reg.start})
                 && (len_sum <= {1'b0, MAX_RUN_LENGTH})
                 && (b_item_reg.owner[OWNER_W-1]
                     || ((entry.flags == b_item_reg.flags)
                         && (off_sum == {1'b0, b_item_reg.offset})));

        new_rec = entry;
        emit    = 1'b0;
        if (b_item_reg.cmd == CMD_FLUSH)
        begin
            emit          = entry.valid;
            new_rec.valid = 1'b0;
        end
        else if (!entry.valid)
        begin
            new_rec = load_rec;
        end
        else if (can_merge)
        begin
            new_rec.length = len_sum[RUNLEN_W-1:0];
        end
        else
        begin
            emit    = 1'b1;
            new_rec = load_rec;
        end
    end

    always_comb
    begin
        wr_en   = clr_busy_reg || b_fire;
        wr_addr = clr_busy_reg ? clr_cnt_reg : b_addr;
        wr_data = clr_busy_reg ? rec_t'('0) : new_rec;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tbl_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rd_reg <= tbl_mem[head_item.group[GW-1:0]];
    end

    // Sweep the table once after reset to drop stale records
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == GW'(GROUP_COUNT - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                b_valid_reg   <= pop;
                fwd_valid_reg <= b_fire;
            end
            if (b_fire && emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_item_reg   <= head_item;
            fwd_addr_reg <= b_addr;
            fwd_rec_reg  <= new_rec;
        end
        if (b_fire && emit)
        begin
            out_item_reg <= b_item_reg;
            out_rec_reg  <= entry;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_group       = out_item_reg.group[OGROUP_W-1:0];
    assign out_owner       = out_rec_reg.owner;
    assign out_start_block = out_rec_reg.start;
    assign out_length      = out_rec_reg.length;
    assign out_offset      = out_rec_reg.offset;
    assign out_attr_fork   = out_rec_reg.flags[0];
    assign out_unwritten   = out_rec_reg.flags[1];

endmodule

`default_nettype wire

### sv/extent_run_coalescer.sv
// Channel | Handshake            | Carries
// --------+----------------------+-------------------------------------------
// cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (enable, group shift)
// in      | in_valid/in_stall    | extent add or group flush request
// out     | out_valid/out_stall  | emitted merged record, at most one per request
//
// One request per cycle sustained while out_stall is low and the table sweep is over. An
// accepted request is written into the queue; once popped from the queue head it
// reads the group table into the merge stage, and the merge result is registered
// into the output. The group table read-modify-write is one per cycle while the back
// end advances, with the last write forwarded for back-to-back requests to a group.
// After reset the table is swept with in_stall held high.
// A stalled output backs up the queue; in_stall rises once the queue is full.
// Depends on erc_pkg, erc_front, erc_queue and erc_back.
`default_nettype none

module extent_run_coalescer
    import erc_pkg::*;
#(
    parameter int          GROUP_COUNT    = 16,
    parameter logic [31:0] MAX_RUN_LENGTH = 32'hFFFF_FFFF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  command,
    input  wire logic [OWNER_W-1:0]    owner_id,
    input  wire logic                  attr_fork,
    input  wire logic                  unwritten,
    input  wire logic [FSB_W-1:0]      start_fs_block,
    input  wire logic [OFFSET_W-1:0]   logical_offset,
    input  wire logic [LEN_W-1:0]      length,
    input  wire logic [FGROUP_W-1:0]   flush_group,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [OGROUP_W-1:0]        out_group,
    output logic [OWNER_W-1:0]         out_owner,
    output logic [START_W-1:0]         out_start_block,
    output logic [RUNLEN_W-1:0]        out_length,
    output logic [OFFSET_W-1:0]        out_offset,
    output logic                       out_attr_fork,
    output logic                       out_unwritten
);

    logic  q_push;
    item_t q_item;
    logic  q_full;
    logic  q_pop;
    logic  q_head_valid;
    item_t q_head_item;
    logic  clearing;

    erc_front #(
        .GROUP_COUNT (GROUP_COUNT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .owner_id       (owner_id),
        .attr_fork      (attr_fork),
        .unwritten      (unwritten),
        .start_fs_block (start_fs_block),
        .logical_offset (logical_offset),
        .length         (length),
        .flush_group    (flush_group),
        .q_full         (q_full),
        .clearing       (clearing),
        .q_push         (q_push),
        .q_item         (q_item)
    );

    erc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    erc_back #(
        .GROUP_COUNT    (GROUP_COUNT),
        .MAX_RUN_LENGTH (MAX_RUN_LENGTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (q_head_valid),
        .head_item       (q_head_item),
        .pop             (q_pop),
        .clearing        (clearing),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_group       (out_group),
        .out_owner       (out_owner),
        .out_start_block (out_start_block),
        .out_length      (out_length),
        .out_offset      (out_offset),
        .out_attr_fork   (out_attr_fork),
        .out_unwritten   (out_unwritten)
    );

endmodule

`default_nettype wire

### sv/erc_checker.sv
// Port-level checks for the extent run coalescer, bound to the top level.
// Depends on erc_pkg and extent_run_coalescer.
`default_nettype none

module erc_checker
    import erc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [OGROUP_W-1:0]   out_group,
    input wire logic [OWNER_W-1:0]    out_owner,
    input wire logic [START_W-1:0]    out_start_block,
    input wire logic [RUNLEN_W-1:0]   out_length,
    input wire logic [OFFSET_W-1:0]   out_offset
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_owner)
            && $stable(out_length) && $stable(out_offset) && $stable(out_group))
        else $error("stalled result changed");

    // The table sweep blocks requests right after reset
    a_sweep_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("request taken during table sweep");

    // Configuration writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

    // Group-relative start never exceeds 31 bits
    a_start_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !out_start_block[START_W-1])
        else $error("group-relative start out of range");

endmodule

bind extent_run_coalescer erc_checker u_erc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_group       (out_group),
    .out_owner       (out_owner),
    .out_start_block (out_start_block),
    .out_length      (out_length),
    .out_offset      (out_offset)
);

`default_nettype wire
